@@ hw/rtl/lpc_pkg.sv @@
// Shared types and constants for the lidar polar-to-cartesian block.
// Depends on nothing; every lpc_* module and the top level use it.
package lpc_pkg;

    // Configuration register indexes
    localparam int          CFG_IDX_W        = 3;
    localparam logic [2:0]  REG_RANGE_LOWER  = 3'd0;
    localparam logic [2:0]  REG_RANGE_UPPER  = 3'd1;
    localparam logic [2:0]  REG_START_ANGLE  = 3'd2;
    localparam logic [2:0]  REG_ANGLE_STEP   = 3'd3;
    localparam logic [2:0]  REG_POSE_X_POS   = 3'd4;
    localparam logic [2:0]  REG_POSE_Y_POS   = 3'd5;
    localparam logic [2:0]  REG_POSE_HEADING = 3'd6;

    // CORDIC datapath widths: x/y carry r*2^16 plus rotation growth, z the residual angle
    localparam int XW = 36;
    localparam int ZW = 33;

    // Inverse CORDIC gain, Q30
    localparam logic [29:0] GAIN_Q30 = 30'd652032874;

    // atan(2^-i) in binary-angle units (full turn = 2^32)
    localparam logic [31:0] ATAN_TABLE [32] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
        32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
        32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
        32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000
    };

    typedef struct packed {
        logic [15:0] range_sample;
        logic [11:0] beam_index;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic [11:0]        point_beam;
    } point_t;

    typedef struct packed {
        logic [15:0]        range_lower;
        logic [15:0]        range_upper;
        logic [31:0]        start_angle;
        logic [31:0]        angle_step;
        logic signed [31:0] pose_x_pos;
        logic signed [31:0] pose_y_pos;
        logic [31:0]        pose_heading;
    } cfg_t;

    // Vector handed from cell to cell
    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic [11:0]          beam;
    } cord_t;

endpackage

@@ hw/rtl/lidar_polar_to_cartesian.sv @@
// Lidar beam to world point converter: top level with configuration registers.
// Depends on lpc_pkg, lpc_front, lpc_cordic_cell and lpc_back.
//
// Usage:
//   sample channel (sample_valid/sample_ready/sample) takes one range sample and
//   its beam index per transaction. Beams whose index is not a multiple of
//   DECIMATION, at or beyond MAX_BEAMS, or whose range is outside
//   [range_lower, range_upper] are dropped and produce no point.
//   point channel (point_valid/point_ready/point) returns world x/y and the beam.
//   cfg channel writes one register per transaction (cfg_index, cfg_data);
//   cfg_ready is always high. Write only while no samples are in flight.
// Pipeline: 3 front stages, one cell per CORDIC micro-rotation, one output
//   register; NSTG is CORDIC_STAGES capped at 32, so 16 by default.
// Throughput: one sample per cycle. Every stage holds a valid bit and only
//   stalls when it is full and its successor stalls, so dropped samples leave
//   bubbles that are squeezed out under back-pressure.
// Reset: all valid bits clear, registers return to range_upper = 65535 and
//   zero elsewhere. When point_ready is low the output holds its point and
//   the pipeline keeps filling until every stage is occupied.
module lidar_polar_to_cartesian #(
    parameter int DECIMATION    = 3,
    parameter int MAX_BEAMS     = 4096,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sample_valid,
    output logic                              sample_ready,
    input  lpc_pkg::sample_t                   sample,
    output logic                              point_valid,
    input  logic                              point_ready,
    output lpc_pkg::point_t                    point,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]                       cfg_data
);

    // more than 32 micro-rotations add nothing at 32-bit angles
    localparam int NSTG = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

    lpc_pkg::cfg_t  cfg_reg;
    lpc_pkg::cfg_t  cfg_next;

    // stg_*[i] feeds cell i; stg_*[NSTG] feeds the back end
    logic           stg_valid [NSTG+1];
    logic           stg_ready [NSTG+1];
    lpc_pkg::cord_t stg_data  [NSTG+1];

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                lpc_pkg::REG_RANGE_LOWER:  cfg_next.range_lower  = cfg_data[15:0];
                lpc_pkg::REG_RANGE_UPPER:  cfg_next.range_upper  = cfg_data[15:0];
                lpc_pkg::REG_START_ANGLE:  cfg_next.start_angle  = cfg_data;
                lpc_pkg::REG_ANGLE_STEP:   cfg_next.angle_step   = cfg_data;
                lpc_pkg::REG_POSE_X_POS:   cfg_next.pose_x_pos   = cfg_data;
                lpc_pkg::REG_POSE_Y_POS:   cfg_next.pose_y_pos   = cfg_data;
                lpc_pkg::REG_POSE_HEADING: cfg_next.pose_heading = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.range_lower  <= '0;
            cfg_reg.range_upper  <= 16'hFFFF;
            cfg_reg.start_angle  <= '0;
            cfg_reg.angle_step   <= '0;
            cfg_reg.pose_x_pos   <= '0;
            cfg_reg.pose_y_pos   <= '0;
            cfg_reg.pose_heading <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ---------------------------------------------------------------
    // Filter, angle and start vector
    // ---------------------------------------------------------------
    lpc_front #(
        .DECIMATION (DECIMATION),
        .MAX_BEAMS  (MAX_BEAMS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .cord_valid   (stg_valid[0]),
        .cord_ready   (stg_ready[0]),
        .cord         (stg_data[0])
    );

    // ---------------------------------------------------------------
    // Row of CORDIC cells, one micro-rotation each
    // ---------------------------------------------------------------
    for (genvar i = 0; i < NSTG; i++)
    begin : g_cell
        lpc_cordic_cell #(
            .IDX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (stg_valid[i]),
            .up_ready (stg_ready[i]),
            .up       (stg_data[i]),
            .dn_valid (stg_valid[i+1]),
            .dn_ready (stg_ready[i+1]),
            .dn       (stg_data[i+1])
        );
    end

    // ---------------------------------------------------------------
    // Pose offset, saturation, output register
    // ---------------------------------------------------------------
    lpc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .up_valid    (stg_valid[NSTG]),
        .up_ready    (stg_ready[NSTG]),
        .up          (stg_data[NSTG]),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .point       (point)
    );

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // empty output register means every stage upstream can move
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !point_valid |-> sample_ready)
        else $error("sample_ready low with empty output register");

    a_beam_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid |-> ({5'b0, point.point_beam} < 17'(MAX_BEAMS)))
        else $error("point from beam beyond MAX_BEAMS");

    a_no_point_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !point_valid)
        else $error("point presented right after reset");

endmodule

@@ hw/rtl/lpc_front.sv @@
// Front end: beam/range filter, beam angle, half-turn reduction, start vector.
// Depends on lpc_pkg. Three pipeline stages with bubble collapsing.
module lpc_front #(
    parameter int DECIMATION = 3,
    parameter int MAX_BEAMS  = 4096
) (
    input  logic            clk,
    input  logic            rst_n,
    input  lpc_pkg::cfg_t    cfg,
    input  logic            sample_valid,
    output logic            sample_ready,
    input  lpc_pkg::sample_t sample,
    output logic            cord_valid,
    input  logic            cord_ready,
    output lpc_pkg::cord_t   cord
);

    // beam / DECIMATION by reciprocal: exact for 12-bit beams when K >= 12 + log2(16)
    localparam int          K   = 17;
    localparam int          MUL = ((2 ** K) + DECIMATION - 1) / DECIMATION;
    localparam int          XW  = lpc_pkg::XW;
    localparam int          ZW  = lpc_pkg::ZW;

    // stage A: filter on range and index, quotient estimate
    logic        a_vld_reg;
    logic [15:0] a_range_reg;
    logic [11:0] a_beam_reg;
    logic [11:0] a_quot_reg;
    logic        a_ready;
    logic        a_keep;
    logic [29:0] a_prod;

    // stage B: decimation check, index * step
    logic        b_vld_reg;
    logic [15:0] b_range_reg;
    logic [11:0] b_beam_reg;
    logic [31:0] b_step_reg;
    logic        b_ready;
    logic        b_keep;
    logic [16:0] b_back;
    logic [43:0] b_prod;

    // stage C: angle sum, reduction, start vector
    logic           c_vld_reg;
    lpc_pkg::cord_t c_reg;
    lpc_pkg::cord_t c_next;
    logic           c_ready;
    logic [31:0]    c_ang;
    logic           c_wrap;
    logic [31:0]    c_zang;
    logic [45:0]    c_gprod;
    logic signed [XW-1:0] c_x0;

    assign a_keep = (sample.range_sample >= cfg.range_lower)
                 && (sample.range_sample <= cfg.range_upper)
                 && (17'(sample.beam_index) < 17'(MAX_BEAMS));
    assign a_prod = 30'(sample.beam_index) * 30'(MUL);
    assign a_ready = !a_vld_reg || b_ready;
    assign sample_ready = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_vld_reg <= sample_valid && a_keep;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && sample_valid)
        begin
            a_range_reg <= sample.range_sample;
            a_beam_reg  <= sample.beam_index;
            a_quot_reg  <= a_prod[K+11:K];
        end
    end

    assign b_back  = 17'(a_quot_reg) * 17'(DECIMATION);
    assign b_keep  = (b_back == 17'(a_beam_reg));
    assign b_prod  = 44'(a_beam_reg) * 44'(cfg.angle_step);
    assign b_ready = !b_vld_reg || c_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_vld_reg <= a_vld_reg && b_keep;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_vld_reg)
        begin
            b_range_reg <= a_range_reg;
            b_beam_reg  <= a_beam_reg;
            b_step_reg  <= b_prod[31:0];
        end
    end

    // angle outside [-quarter, +quarter] turn: negate vector, rotate by half a turn
    assign c_ang   = cfg.start_angle + b_step_reg + cfg.pose_heading;
    assign c_wrap  = ($signed(c_ang) > 32'sh4000_0000) || ($signed(c_ang) < -32'sh4000_0000);
    assign c_zang  = c_wrap ? (c_ang ^ 32'h8000_0000) : c_ang;
    assign c_gprod = 46'(b_range_reg) * 46'(lpc_pkg::GAIN_Q30) + 46'd8192;
    assign c_x0    = $signed({{(XW-32){1'b0}}, c_gprod[45:14]});

    always_comb
    begin
        c_next.x    = c_wrap ? -c_x0 : c_x0;
        c_next.y    = '0;
        c_next.z    = $signed({{(ZW-32){c_zang[31]}}, c_zang});
        c_next.beam = b_beam_reg;
    end

    assign c_ready = !c_vld_reg || cord_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_vld_reg <= 1'b0;
        end
        else if (c_ready)
        begin
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_ready && b_vld_reg)
        begin
            c_reg <= c_next;
        end
    end

    assign cord_valid = c_vld_reg;
    assign cord       = c_reg;

endmodule

@@ hw/rtl/lpc_cordic_cell.sv @@
// One rotation-mode CORDIC micro-rotation with its pipeline register.
// Depends on lpc_pkg (vector type, atan table).
module lpc_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          up_valid,
    output logic          up_ready,
    input  lpc_pkg::cord_t up,
    output logic          dn_valid,
    input  logic          dn_ready,
    output lpc_pkg::cord_t dn
);

    localparam int XW = lpc_pkg::XW;
    localparam int ZW = lpc_pkg::ZW;

    logic           vld_reg;
    lpc_pkg::cord_t data_reg;
    lpc_pkg::cord_t data_next;
    logic signed [XW-1:0] sx;
    logic signed [XW-1:0] sy;
    logic signed [ZW-1:0] tval;

    // arithmetic shift = floor division by 2^IDX
    assign sx   = $signed(up.x) >>> IDX;
    assign sy   = $signed(up.y) >>> IDX;
    assign tval = $signed({{(ZW-32){1'b0}}, lpc_pkg::ATAN_TABLE[IDX]});

    always_comb
    begin
        data_next.beam = up.beam;
        if (!up.z[ZW-1])
        begin
            data_next.x = up.x - sy;
            data_next.y = up.y + sx;
            data_next.z = up.z - tval;
        end
        else
        begin
            data_next.x = up.x + sy;
            data_next.y = up.y - sx;
            data_next.z = up.z + tval;
        end
    end

    assign up_ready = !vld_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            vld_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = vld_reg;
    assign dn       = data_reg;

endmodule

@@ hw/rtl/lpc_back.sv @@
// Back end: round the rotated vector to 1/1024 m, add the pose, saturate.
// Depends on lpc_pkg. Holds the output register of the block.
module lpc_back (
    input  logic           clk,
    input  logic           rst_n,
    input  lpc_pkg::cfg_t   cfg,
    input  logic           up_valid,
    output logic           up_ready,
    input  lpc_pkg::cord_t  up,
    output logic           point_valid,
    input  logic           point_ready,
    output lpc_pkg::point_t point
);

    localparam int XW = lpc_pkg::XW;
    localparam int DW = XW - 16;

    logic            vld_reg;
    lpc_pkg::point_t pt_reg;
    lpc_pkg::point_t pt_next;
    logic signed [XW-1:0] xr;
    logic signed [XW-1:0] yr;
    logic signed [33:0]   sum_x;
    logic signed [33:0]   sum_y;

    function automatic logic [31:0] sat32(input logic signed [33:0] v);
        logic [31:0] res;
        if ((v[33:31] == 3'b000) || (v[33:31] == 3'b111))
        begin
            res = v[31:0];
        end
        else if (v[33])
        begin
            res = 32'h8000_0000;
        end
        else
        begin
            res = 32'h7FFF_FFFF;
        end
        return res;
    endfunction

    // round half up, then floor shift by 16
    assign xr = up.x + $signed(XW'(32768));
    assign yr = up.y + $signed(XW'(32768));

    assign sum_x = $signed({{2{cfg.pose_x_pos[31]}}, cfg.pose_x_pos})
                 + $signed({{(34-DW){xr[XW-1]}}, xr[XW-1:16]});
    assign sum_y = $signed({{2{cfg.pose_y_pos[31]}}, cfg.pose_y_pos})
                 + $signed({{(34-DW){yr[XW-1]}}, yr[XW-1:16]});

    always_comb
    begin
        pt_next.point_x    = sat32(sum_x);
        pt_next.point_y    = sat32(sum_y);
        pt_next.point_beam = up.beam;
    end

    assign up_ready = !vld_reg || point_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            vld_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            pt_reg <= pt_next;
        end
    end

    assign point_valid = vld_reg;
    assign point       = pt_reg;

endmodule
